// ===== rtl/core/sobm_pkg.sv =====
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// sine oscillator bank.
// ----------------------------------------------------------------------------
package sobm_pkg;

  localparam int unsigned VOICES          = 4;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned REG_VOICES      = 4;
  localparam int unsigned TABLE_N         = 1 << SINE_TABLE_BITS;
  localparam int unsigned TBL_AW          = SINE_TABLE_BITS + 1;
  localparam int unsigned CNT_W           = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;

  localparam logic [PHASE_W-1:0] STEP_RESET  = 32'd42852281;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 16'h8000;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]        FULL_SCALE  = 64'd32767;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_STEP0  = 3'd1,
    REG_STEP1  = 3'd2,
    REG_STEP2  = 3'd3,
    REG_STEP3  = 3'd4,
    REG_GAINS  = 3'd5
  } reg_idx_e;

  // one voice's state, as it travels along the ring
  typedef struct packed {
    logic               en;
    logic [GAIN_W-1:0]  gain;
    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  // register writes aimed at one cell
  typedef struct packed {
    logic               en_we;
    logic               en;
    logic               step_we;
    logic [PHASE_W-1:0] step;
    logic               gain_we;
    logic [GAIN_W-1:0]  gain;
  } cell_cfg_t;

  function automatic logic [63:0] next_term(logic [63:0] term, logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : 64'd0;
  endfunction

  // sin(x), x and result in Q30, Taylor series to the 17th power
  function automatic logic [63:0] q30_sine(logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = x;
    term = x;
    term = next_term(term, x) / 64'd6;   sum = sat_sub(sum, term);
    term = next_term(term, x) / 64'd20;  sum = sum + term;
    term = next_term(term, x) / 64'd42;  sum = sat_sub(sum, term);
    term = next_term(term, x) / 64'd72;  sum = sum + term;
    term = next_term(term, x) / 64'd110; sum = sat_sub(sum, term);
    term = next_term(term, x) / 64'd156; sum = sum + term;
    term = next_term(term, x) / 64'd210; sum = sat_sub(sum, term);
    term = next_term(term, x) / 64'd272; sum = sum + term;
    return sum;
  endfunction

  // one quarter-wave table entry; the last entry is pinned to full scale
  function automatic logic [MAG_W-1:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] v;
    x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    v = (q30_sine(x) * FULL_SCALE) >> 30;
    if (v > FULL_SCALE || k == TABLE_N) begin
      v = FULL_SCALE;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sobm_cell.sv =====
// ----------------------------------------------------------------------------
// sobm_cell
// One slot of the voice ring: holds a voice's phase, step, gain and enable,
// takes its neighbor's word on a shift, else takes register writes.
// ----------------------------------------------------------------------------
module sobm_cell
  import sobm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  voice_t    word_i,
  input  cell_cfg_t cfg_i,
  output voice_t    word_o
);

  voice_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q.en    <= 1'b0;
      word_q.gain  <= UNITY_GAIN;
      word_q.step  <= STEP_RESET;
      word_q.phase <= '0;
    end else if (shift_i) begin
      word_q <= word_i;
    end else begin
      if (cfg_i.en_we) begin
        word_q.en <= cfg_i.en;
      end
      if (cfg_i.step_we) begin
        word_q.step <= cfg_i.step;
      end
      if (cfg_i.gain_we) begin
        word_q.gain <= cfg_i.gain;
      end
    end
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/sobm_sine_unit.sv =====
// ----------------------------------------------------------------------------
// sobm_sine_unit
// Shared voice datapath: quarter-wave ROM lookup, gain multiply, sign.
// Three register stages from phase in to signed sample out.
// ----------------------------------------------------------------------------
module sobm_sine_unit
  import sobm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [PHASE_W-1:0] phase_i,
  input  logic [GAIN_W-1:0]  gain_i,
  output logic               valid_o,
  output logic [SMP_W-1:0]   sample_o
);

  localparam int unsigned PROD_W = MAG_W + GAIN_W;

  logic [MAG_W-1:0] sine_rom [TABLE_N+1];

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [TBL_AW-1:0]          addr;

  logic [MAG_W-1:0]  mag_q;
  logic [GAIN_W-1:0] a_gain_q;
  logic              a_neg_q, a_vld_q;
  logic [PROD_W-1:0] prod_q;
  logic              b_neg_q, b_vld_q;
  logic [SMP_W-1:0]  scaled;
  logic [SMP_W-1:0]  smp_q;
  logic              c_vld_q;

  for (genvar k = 0; k <= int'(TABLE_N); k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  assign idx  = phase_i[PHASE_W-3 -: SINE_TABLE_BITS];
  // odd quadrants run the table backwards
  assign addr = phase_i[PHASE_W-2] ? (TBL_AW'(TABLE_N) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    mag_q    <= sine_rom[addr];
    a_gain_q <= gain_i;
    a_neg_q  <= phase_i[PHASE_W-1];
    prod_q   <= PROD_W'(mag_q) * PROD_W'(a_gain_q);
    b_neg_q  <= a_neg_q;
    smp_q    <= b_neg_q ? (SMP_W'(0) - scaled) : scaled;
  end

  assign scaled = prod_q[PROD_W-1:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  assign valid_o  = c_vld_q;
  assign sample_o = smp_q;

endmodule

// ===== rtl/core/sine_oscillator_bank_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// sine_oscillator_bank_mixer_unit
// A tick word accepted in idle starts a run: the voice ring steps once per
// cycle through the one shared sine/multiply unit, the unit's three stages
// drain, and the mix is loaded into the output register once that is free.
// No tick word is taken until then. A tick word of zero is taken and dropped.
// Reset (async, active low) zeroes all phases, disables all voices, loads the
// 440 Hz step and unity gain; the output register comes up empty.
// ----------------------------------------------------------------------------
module sine_oscillator_bank_mixer_unit
  import sobm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tick channel
  input  logic                    tick_valid_i,
  output logic                    tick_stall_o,
  input  logic                    tick_i,
  // sample channel
  output logic                    mixed_sample_valid_o,
  input  logic                    mixed_sample_stall_i,
  output logic signed [SMP_W-1:0] mixed_sample_o,
  // register writes
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       drain_q;
  logic [SMP_W-1:0] acc_q;
  logic [SMP_W-1:0] smp_q;
  logic             out_vld_q;

  logic tick_acc;
  logic run;

  assign tick_acc     = tick_valid_i && (state_q == ST_IDLE);
  assign tick_stall_o = (state_q != ST_IDLE);
  assign run          = (state_q == ST_RUN);

  // --------------------------------------------------------------------------
  // Register decode. Steps above half a turn are dropped; gains above unity
  // are clipped on the way in so the datapath only ever sees <= 0x8000.
  // --------------------------------------------------------------------------
  logic [REG_VOICES-1:0] step_sel;
  logic                  en_wr, gains_wr;
  logic                  step_ok;

  assign step_ok = !cfg_data_i[31] || (cfg_data_i[30:0] == '0);

  always_comb begin
    step_sel = '0;
    en_wr    = 1'b0;
    gains_wr = 1'b0;
    unique case (reg_idx_e'(cfg_index_i))
      REG_ENABLE: en_wr       = 1'b1;
      REG_STEP0:  step_sel[0] = 1'b1;
      REG_STEP1:  step_sel[1] = 1'b1;
      REG_STEP2:  step_sel[2] = 1'b1;
      REG_STEP3:  step_sel[3] = 1'b1;
      REG_GAINS:  gains_wr    = 1'b1;
      default:    ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Voice ring. Cell 0 is the head that feeds the sine unit; during a run the
  // ring turns once per cycle and the head word re-enters at the tail with
  // its phase advanced if it is enabled. After a run every voice is back in its
  // slot, so register writes land on the right voice; writes during a run are lost.
  // --------------------------------------------------------------------------
  voice_t cell_w [VOICES];
  voice_t head_adv;

  always_comb begin
    head_adv = cell_w[0];
    if (cell_w[0].en) begin
      head_adv.phase = cell_w[0].phase + cell_w[0].step;
    end
  end

  for (genvar i = 0; i < int'(VOICES); i++) begin : g_cell
    cell_cfg_t cfg;
    voice_t    nxt;
    logic [GAIN_W-1:0] g_raw;

    if (i < int'(REG_VOICES)) begin : g_regs
      assign g_raw       = cfg_data_i[GAIN_W*i +: GAIN_W];
      assign cfg.en_we   = cfg_we_i && en_wr;
      assign cfg.en      = cfg_data_i[i];
      assign cfg.step_we = cfg_we_i && step_sel[i] && step_ok;
      assign cfg.step    = cfg_data_i[PHASE_W-1:0];
      assign cfg.gain_we = cfg_we_i && gains_wr;
      assign cfg.gain    = (g_raw > UNITY_GAIN) ? UNITY_GAIN : g_raw;
    end else begin : g_noregs
      // voices past the register set never play
      assign g_raw = '0;
      assign cfg   = '0;
    end

    if (i == int'(VOICES) - 1) begin : g_tail
      assign nxt = head_adv;
    end else begin : g_mid
      assign nxt = cell_w[i+1];
    end

    sobm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (run),
      .word_i  (nxt),
      .cfg_i   (cfg),
      .word_o  (cell_w[i])
    );
  end

  // --------------------------------------------------------------------------
  // Shared sine and gain unit, fed from the head cell.
  // --------------------------------------------------------------------------
  logic             vs_vld;
  logic [SMP_W-1:0] vs_smp;

  sobm_sine_unit u_sine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (run && cell_w[0].en),
    .phase_i  (cell_w[0].phase),
    .gain_i   (cell_w[0].gain),
    .valid_o  (vs_vld),
    .sample_o (vs_smp)
  );

  // --------------------------------------------------------------------------
  // Sequencer, mixer accumulator and output register. The mix wraps at
  // 16 bits, so only the low 16 bits of each voice output are summed.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      drain_q   <= '0;
      acc_q     <= '0;
      smp_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded or held below
      if (out_vld_q && !mixed_sample_stall_i && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end
      if (vs_vld) begin
        acc_q <= acc_q + vs_smp;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (tick_acc && tick_i) begin
            state_q <= ST_RUN;
            cnt_q   <= '0;
            acc_q   <= '0;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(VOICES - 1)) begin
            state_q <= ST_DRAIN;
            drain_q <= '0;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd2) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the output register to be free
          if (!out_vld_q || !mixed_sample_stall_i) begin
            smp_q     <= acc_q;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign mixed_sample_valid_o = out_vld_q;
  assign mixed_sample_o       = $signed(smp_q);

endmodule

// ===== test/sobm_mix_checker.sv =====
// ----------------------------------------------------------------------------
// sobm_mix_checker
// Watches the tick, sample and register-write ports of the oscillator bank.
// Keeps its own copy of the phases and registers, works out the mixed sample
// that each accepted tick must give, and compares the samples in order.
// ----------------------------------------------------------------------------
module sobm_mix_checker
  import sobm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_valid_i,
  input  logic                    tick_stall_i,
  input  logic                    tick_i,
  input  logic                    mixed_sample_valid_i,
  input  logic                    mixed_sample_stall_i,
  input  logic signed [SMP_W-1:0] mixed_sample_i,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output int unsigned             mismatches_o,
  output int unsigned             outstanding_o,
  output int unsigned             samples_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PHASE_W-1:0] NYQUIST_STEP = 32'h8000_0000;
  localparam int unsigned        SLOT_W       = $clog2(REG_VOICES);

  logic [MAG_W-1:0]        sine_mag [TABLE_N+1];
  logic [REG_VOICES-1:0]   play_mask;
  logic [PHASE_W-1:0]      step_q   [REG_VOICES];
  logic [CFG_W-1:0]        gains_q;
  logic [PHASE_W-1:0]      phase_q  [VOICES];
  logic signed [SMP_W-1:0] expected_mix_q [$];

  // sin(x) in Q30 for 0 <= x <= pi/2, odd Taylor terms up to x^17
  function automatic logic [63:0] quarter_sine_q30(logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = x;
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] mag;
    for (int k = 0; k <= int'(TABLE_N); k++) begin
      mag = (quarter_sine_q30((HALF_PI_Q30 * 64'(k)) / 64'(TABLE_N)) * 64'd32767) >> 30;
      sine_mag[k] = (mag > 64'd32767) ? 15'h7FFF : mag[MAG_W-1:0];
    end
    sine_mag[TABLE_N] = 15'h7FFF;
  end

  // one tick: sum the playing voices, then advance their phases
  function automatic logic [SMP_W-1:0] advance_voices();
    logic [31:0]                acc;
    logic [GAIN_W-1:0]          gain;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [MAG_W-1:0]           mag;
    logic [31:0]                scaled;
    acc = '0;
    for (int v = 0; v < int'(VOICES); v++) begin
      if (v < int'(REG_VOICES) && play_mask[v]) begin
        gain = gains_q[GAIN_W*v +: GAIN_W];
        if (gain > UNITY_GAIN) begin
          gain = UNITY_GAIN;
        end
        quad   = phase_q[v][PHASE_W-1 -: 2];
        idx    = phase_q[v][PHASE_W-3 -: SINE_TABLE_BITS];
        mag    = quad[0] ? sine_mag[TBL_AW'(TABLE_N - idx)] : sine_mag[{1'b0, idx}];
        scaled = (32'(mag) * 32'(gain)) >> 15;
        acc    = quad[1] ? acc - scaled : acc + scaled;
        phase_q[v] = phase_q[v] + step_q[v];
      end
    end
    return acc[SMP_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [SMP_W-1:0] want;
    if (!rst_ni) begin
      play_mask = '0;
      gains_q   = {4{UNITY_GAIN}};
      for (int v = 0; v < int'(REG_VOICES); v++) begin
        step_q[v] = STEP_RESET;
      end
      for (int v = 0; v < int'(VOICES); v++) begin
        phase_q[v] = '0;
      end
      expected_mix_q.delete();
      mismatches_o      = 0;
      samples_checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLE: play_mask = cfg_data_i[REG_VOICES-1:0];
          REG_STEP0, REG_STEP1, REG_STEP2, REG_STEP3: begin
            // steps past half a turn are refused
            if (cfg_data_i[PHASE_W-1:0] <= NYQUIST_STEP) begin
              step_q[SLOT_W'(cfg_index_i - REG_STEP0)] = cfg_data_i[PHASE_W-1:0];
            end
          end
          REG_GAINS: gains_q = cfg_data_i;
          default: ;
        endcase
      end
      if (mixed_sample_valid_i && !mixed_sample_stall_i) begin
        if (expected_mix_q.size() == 0) begin
          $error("mixed_sample: none expected, actual %0d", mixed_sample_i);
          mismatches_o++;
        end else begin
          want = expected_mix_q.pop_front();
          samples_checked_o++;
          if (mixed_sample_i !== want) begin
            $error("mixed_sample: expected %0d, actual %0d", want, mixed_sample_i);
            mismatches_o++;
          end
        end
      end
      // a zero tick is taken and dropped
      if (tick_valid_i && !tick_stall_i && tick_i) begin
        expected_mix_q.push_back(advance_voices());
      end
    end
    outstanding_o = expected_mix_q.size();
  end

endmodule

// ===== test/sine_oscillator_bank_mixer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sine_oscillator_bank_mixer_unit_tb
// Drives tick words and register writes into the oscillator bank and random
// stall on its sample output; a side checker predicts and compares every
// mixed sample. Directed settings first, then random register settings.
// ----------------------------------------------------------------------------
module sine_oscillator_bank_mixer_unit_tb;
  import sobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_TICKS   = 1900;
  localparam int unsigned DRAIN_CYCLES   = 2 * (VOICES + 5);
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned GAP_PERCENT    = 22;

  // indexes that decode to no register
  localparam logic [IDX_W-1:0]   REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0]   REG_SPARE_HI = 3'd7;
  localparam logic [PHASE_W-1:0] NYQUIST_STEP = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  logic                    clk_i                = 1'b0;
  logic                    rst_ni               = 1'b0;
  logic                    tick_valid_i         = 1'b0;
  logic                    tick_stall_o;
  logic                    tick_i               = 1'b0;
  logic                    mixed_sample_valid_o;
  logic                    mixed_sample_stall_i = 1'b0;
  logic signed [SMP_W-1:0] mixed_sample_o;
  logic                    cfg_we_i             = 1'b0;
  logic [IDX_W-1:0]        cfg_index_i          = REG_ENABLE;
  logic [CFG_W-1:0]        cfg_data_i           = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned samples_checked;

  // random gaps on both sides; cleared for a stretch of the random part
  logic        gaps_on  = 1'b1;
  // asks the sample sink for one long hold-off
  logic        hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  sine_oscillator_bank_mixer_unit i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .tick_valid_i         (tick_valid_i),
    .tick_stall_o         (tick_stall_o),
    .tick_i               (tick_i),
    .mixed_sample_valid_o (mixed_sample_valid_o),
    .mixed_sample_stall_i (mixed_sample_stall_i),
    .mixed_sample_o       (mixed_sample_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  sobm_mix_checker i_mix_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .tick_valid_i         (tick_valid_i),
    .tick_stall_i         (tick_stall_o),
    .tick_i               (tick_i),
    .mixed_sample_valid_i (mixed_sample_valid_o),
    .mixed_sample_stall_i (mixed_sample_stall_i),
    .mixed_sample_i       (mixed_sample_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .mismatches_o         (mismatches),
    .outstanding_o        (outstanding),
    .samples_checked_o    (samples_checked)
  );

  // Offer one tick word; entered and left at a falling edge. A gap is decided
  // before valid is raised, so valid never drops and rises in one step.
  task automatic offer_tick(input logic t);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      tick_valid_i = 1'b0;
      tick_i       = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    tick_valid_i = 1'b1;
    tick_i       = t;
    do @(posedge clk_i); while (tick_stall_o);
    @(negedge clk_i);
  endtask

  // Write enable stays high across a batch; the caller lowers it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
  endtask

  // Stop ticks, wait for every predicted sample, then wait out DRAIN_CYCLES
  // more before touching the registers.
  task automatic quiesce();
    tick_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Step data: mostly legal, some right at the limits, some past Nyquist
  // (those must be refused). Upper 32 bits are noise.
  function automatic logic [CFG_W-1:0] pick_step();
    logic [PHASE_W-1:0] s;
    case ($urandom_range(9))
      0:       s = '0;
      1:       s = NYQUIST_STEP;
      2:       s = NYQUIST_STEP + 32'd1 + ($urandom & 32'h7FFF_FFFE);
      3:       s = 32'hFFFF_FFFF;
      4:       s = $urandom_range(1 << 20, 1);
      5:       s = QUARTER_TURN;
      default: s = $urandom_range(NYQUIST_STEP, 0);
    endcase
    return {32'($urandom), s};
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return UNITY_GAIN;
      2:       return 16'hFFFF;
      3:       return UNITY_GAIN + 16'd1;
      4:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic program_random_setting();
    logic [REG_VOICES-1:0] mask;
    quiesce();
    case ($urandom_range(5))
      0:       mask = '0;
      1, 2:    mask = '1;
      default: mask = REG_VOICES'($urandom);
    endcase
    write_reg(REG_ENABLE, {60'({$urandom, $urandom}), mask});
    for (int v = 0; v < int'(REG_VOICES); v++) begin
      write_reg(IDX_W'(REG_STEP0 + v), pick_step());
    end
    write_reg(REG_GAINS, {pick_gain(), pick_gain(), pick_gain(), pick_gain()});
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
    end
    cfg_we_i = 1'b0;
  endtask

  // sample sink: random stall, plus one long hold-off on request
  initial begin : sample_sink
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req             = 1'b0;
        mixed_sample_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        mixed_sample_stall_i = gaps_on && ($urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk_i) begin
    if ((tick_valid_i && !tick_stall_o) || (mixed_sample_valid_o && !mixed_sample_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sine_oscillator_bank_mixer_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned random_ticks;
    int unsigned zero_ticks;
    int unsigned settings;
    int unsigned burst;
    random_ticks = 0;
    zero_ticks   = 0;
    settings     = 0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state: every voice off, so the mix is silent; a zero tick in
    // between must give nothing.
    offer_tick(1'b1);
    offer_tick(1'b0);
    offer_tick(1'b1);

    // All voices at a quarter turn per tick: walks the four quadrants, and
    // hits the table end (full scale) at the odd quadrants.
    quiesce();
    write_reg(REG_ENABLE, 64'hF);
    for (int v = 0; v < int'(REG_VOICES); v++) begin
      write_reg(IDX_W'(REG_STEP0 + v), {32'h0, QUARTER_TURN});
    end
    cfg_we_i = 1'b0;
    repeat (6) offer_tick(1'b1);
    offer_tick(1'b0);
    offer_tick(1'b1);

    // Extremes: Nyquist and zero steps, two refused steps (voices 2 and 3
    // keep the quarter turn), gains above unity saturate, spare indexes
    // are ignored, upper mask bits are ignored.
    quiesce();
    write_reg(REG_STEP0, {32'hFFFF_FFFF, NYQUIST_STEP});
    write_reg(REG_STEP1, 64'h0);
    write_reg(REG_STEP2, {32'h0, NYQUIST_STEP + 32'd1});
    write_reg(REG_STEP3, 64'h0000_0000_FFFF_FFFF);
    write_reg(REG_GAINS, 64'h7FFF_0000_8001_FFFF);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    write_reg(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFB);
    cfg_we_i = 1'b0;
    repeat (8) offer_tick(1'b1);

    // Random settings, each followed by a burst of ticks. The third setting
    // gets the long output hold-off; settings five and six run gap-free.
    while (random_ticks < RANDOM_TICKS) begin
      settings++;
      program_random_setting();
      gaps_on = (settings != 5 && settings != 6);
      if (settings == 3) begin
        hold_req = 1'b1;
      end
      burst = $urandom_range(160, 40);
      repeat (burst) begin
        if ($urandom_range(99) < 8) begin
          offer_tick(1'b0);
          zero_ticks++;
        end else begin
          offer_tick(1'b1);
          random_ticks++;
        end
      end
    end
    quiesce();

    $display("Covered %0d random ticks plus %0d zero ticks over %0d random register settings,",
             random_ticks, zero_ticks, settings);
    $display("after directed quadrant and limit cases; %0d mixed samples compared.",
             samples_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sine_oscillator_bank_mixer_unit test passed");
    end else begin
      $display("sine_oscillator_bank_mixer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sobm_pkg.sv
rtl/core/sobm_cell.sv
rtl/core/sobm_sine_unit.sv
rtl/core/sine_oscillator_bank_mixer_unit.sv
test/sobm_mix_checker.sv
test/sine_oscillator_bank_mixer_unit_tb.sv
